[hdl/cdg2d_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdg2d_pkg
// Shared types and constants for the central-difference gradient block.
// ----------------------------------------------------------------------------
package cdg2d_pkg;

    localparam int DEF_MAX_COLS    = 128;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int ROW_W       = 16;
    localparam int COL_OUT_W   = 7;
    localparam int GRAD_W      = 17;
    localparam int ROWS_REG_W  = 16;
    localparam int COLS_REG_W  = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int OUT_TDATA_W = 64;
    localparam int MIN_DIM     = 3;

    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 16'd128;
    localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd128;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_ROWS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_COLS = 1'd1;

    typedef struct packed {
        logic [ROW_W-1:0]     center_row;
        logic [COL_OUT_W-1:0] center_col;
        logic                 produce;
        logic                 last;
    } pos_t;

endpackage
`default_nettype wire

[hdl/central_difference_gradient_2d.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// central_difference_gradient_2d
// Streaming 2-D central-difference gradient over a row-major sample grid.
//
// Samples enter on the s_axis channel, one per transfer, in row-major order.
// For each interior point the m_axis channel gives its row and column and
// the horizontal and vertical differences (right - left, below - above),
// each read as a value with one fractional bit. Border points give no
// result; tlast marks the last interior point of the grid.
// Grid size is set through the cfg write port (index 0 rows, 1 columns)
// while the block is idle; rows below 3 act as 3, columns clamp to 3..MAX_COLS.
// Throughput is one sample per cycle while no interior sample is held back by
// a stalled m_axis. The result for the sample that completes a neighborhood
// passes the sample stage and registered buffer read, then the result register.
// Reset sets both sizes to 128 and clears the scan counters and window; the
// line buffers are not cleared and are fully rewritten by the first rows.
// When m_axis stalls, the held result stays; border samples keep flowing and
// the next interior sample waits in the sample stage with s_axis_tready low.
// ----------------------------------------------------------------------------
module central_difference_gradient_2d
    import cdg2d_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]               cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                cfg_wdata,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // sample
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // center_row, center_col, grad_col_dir, grad_row_dir, zero pad
    output logic      [OUT_TDATA_W-1:0]               m_axis_tdata,
    // last_of_grid
    output logic                                      m_axis_tlast
);

    localparam int CW = $clog2(MAX_COLS);

    logic                   xfer;
    pos_t                   pos;
    logic [CW-1:0]          col;
    logic [SAMPLE_BITS-1:0] rd_top, rd_mid, wr_top, wr_mid;
    logic                   wr_en;
    logic [CW-1:0]          wr_addr;

    assign xfer = s_axis_tvalid && s_axis_tready;

    cdg2d_scan #(
        .MAX_COLS (MAX_COLS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .xfer      (xfer),
        .pos       (pos),
        .col       (col)
    );

    cdg2d_line_buf #(
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_line_buf (
        .aclk    (aclk),
        .rd_en   (xfer),
        .rd_addr (col),
        .rd_top  (rd_top),
        .rd_mid  (rd_mid),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_top  (wr_top),
        .wr_mid  (wr_mid)
    );

    cdg2d_diff #(
        .MAX_COLS    (MAX_COLS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_diff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_xfer   (xfer),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_pos    (pos),
        .in_col    (col),
        .rd_top    (rd_top),
        .rd_mid    (rd_mid),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_top    (wr_top),
        .wr_mid    (wr_mid),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tlast   (m_axis_tlast)
    );

    // a column is never read in the same cycle it is rewritten
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en && xfer |-> wr_addr != col)
        else $error("line buffer read and write at same column");

endmodule
`default_nettype wire

[hdl/cdg2d_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdg2d_scan
// Grid size registers and row/column scan counters; gives the column of
// each incoming sample and the position of the interior point it completes.
// ----------------------------------------------------------------------------
module cdg2d_scan
    import cdg2d_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]          cfg_wdata,
    input  wire logic                           xfer,
    output pos_t                                pos,
    output logic [$clog2(MAX_COLS)-1:0]         col
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int CFW = (CCW > COLS_REG_W) ? CCW : COLS_REG_W;

    logic [ROWS_REG_W-1:0] grid_rows_reg;
    logic [COLS_REG_W-1:0] grid_cols_reg;
    logic [ROW_W-1:0]      row_count_reg, row_count_next;
    logic [CW-1:0]         col_count_reg, col_count_next;

    logic [CFW-1:0]        cols_ext, cols_eff, c_plus, c_minus;
    logic [ROW_W-1:0]      rows_eff, r_pre, r_cur;
    logic [ROW_W:0]        r_plus;
    logic [CW-1:0]         c_cur;
    logic                  col_wrap, col_end, row_end;

    always_comb begin
        cols_ext = CFW'(grid_cols_reg);
        if (cols_ext < CFW'(MIN_DIM)) begin
            cols_eff = CFW'(MIN_DIM);
        end else if (cols_ext > CFW'(MAX_COLS)) begin
            cols_eff = CFW'(MAX_COLS);
        end else begin
            cols_eff = cols_ext;
        end
        rows_eff = (grid_rows_reg < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : grid_rows_reg;

        // stale column after a size change starts the next row
        col_wrap = CFW'(col_count_reg) >= cols_eff;
        r_pre    = col_wrap ? ROW_W'(row_count_reg + 1'b1) : row_count_reg;
        r_cur    = (r_pre >= rows_eff) ? '0 : r_pre;
        c_cur    = col_wrap ? '0 : col_count_reg;

        c_plus  = CFW'(c_cur) + CFW'(1);
        c_minus = CFW'(c_cur) - CFW'(1);
        r_plus  = {1'b0, r_cur} + (ROW_W+1)'(1);
        col_end = c_plus >= cols_eff;
        row_end = r_plus >= {1'b0, rows_eff};

        if (col_end) begin
            col_count_next = '0;
            row_count_next = row_end ? '0 : r_plus[ROW_W-1:0];
        end else begin
            col_count_next = c_plus[CW-1:0];
            row_count_next = r_cur;
        end

        pos.center_row = ROW_W'(r_cur - 1'b1);
        pos.center_col = c_minus[COL_OUT_W-1:0];
        pos.produce    = (r_cur >= ROW_W'(2)) && (CFW'(c_cur) >= CFW'(2));
        pos.last       = (r_cur == ROW_W'(rows_eff - 1'b1)) && (c_plus == cols_eff);
        col            = c_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= ROWS_RESET;
            grid_cols_reg <= COLS_RESET;
            row_count_reg <= '0;
            col_count_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GRID_ROWS: grid_rows_reg <= cfg_wdata[ROWS_REG_W-1:0];
                    REG_GRID_COLS: grid_cols_reg <= cfg_wdata[COLS_REG_W-1:0];
                    default: ;
                endcase
            end
            if (xfer) begin
                row_count_reg <= row_count_next;
                col_count_reg <= col_count_next;
            end
        end
    end

    // the final interior point always returns the scan to the grid origin
    a_last_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer && pos.last |=> (row_count_reg == '0) && (col_count_reg == '0))
        else $error("scan did not wrap after last point");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer |-> CFW'(col) < cols_eff)
        else $error("column index outside grid");

    a_produce_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer && pos.produce |-> pos.center_row != '1)
        else $error("result on border row");

endmodule
`default_nettype wire

[hdl/cdg2d_line_buf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdg2d_line_buf
// Two line buffers in one memory word per column: the row two back and the
// row one back. One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cdg2d_line_buf
    import cdg2d_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        rd_en,
    input  wire logic [$clog2(MAX_COLS)-1:0] rd_addr,
    output logic      [SAMPLE_BITS-1:0]      rd_top,
    output logic      [SAMPLE_BITS-1:0]      rd_mid,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(MAX_COLS)-1:0] wr_addr,
    input  wire logic [SAMPLE_BITS-1:0]      wr_top,
    input  wire logic [SAMPLE_BITS-1:0]      wr_mid
);

    logic [2*SAMPLE_BITS-1:0] line_mem [MAX_COLS];
    logic [2*SAMPLE_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= {wr_top, wr_mid};
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_top = rd_data_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign rd_mid = rd_data_reg[SAMPLE_BITS-1:0];

endmodule
`default_nettype wire

[hdl/cdg2d_diff.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdg2d_diff
// Sample stage, 3x3 neighborhood window, the two differences and the
// result register with its stream handshake.
// ----------------------------------------------------------------------------
module cdg2d_diff
    import cdg2d_pkg::*;
#(
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_xfer,
    output logic                             in_ready,
    input  wire logic [SAMPLE_BITS-1:0]      in_sample,
    input  pos_t                             in_pos,
    input  wire logic [$clog2(MAX_COLS)-1:0] in_col,
    input  wire logic [SAMPLE_BITS-1:0]      rd_top,
    input  wire logic [SAMPLE_BITS-1:0]      rd_mid,
    output logic                             wr_en,
    output logic      [$clog2(MAX_COLS)-1:0] wr_addr,
    output logic      [SAMPLE_BITS-1:0]      wr_top,
    output logic      [SAMPLE_BITS-1:0]      wr_mid,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [OUT_TDATA_W-1:0]      m_tdata,
    output logic                             m_tlast
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int EW = (SAMPLE_BITS + 1 > GRAD_W) ? SAMPLE_BITS + 1 : GRAD_W;
    localparam int PAD_W = OUT_TDATA_W - ROW_W - COL_OUT_W - 2 * GRAD_W;

    logic                   a_valid_reg;
    logic [SAMPLE_BITS-1:0] a_sample_reg;
    pos_t                   a_pos_reg;
    logic [CW-1:0]          a_col_reg;

    logic [SAMPLE_BITS-1:0] mid_w0_reg, mid_w1_reg, top_held_reg, bottom_held_reg;

    logic                   m_valid_reg;
    logic [ROW_W-1:0]       row_out_reg;
    logic [COL_OUT_W-1:0]   col_out_reg;
    logic [GRAD_W-1:0]      gc_out_reg, gr_out_reg;
    logic                   last_out_reg;

    logic                   advance, load_out;
    logic signed [EW-1:0]   gc_full, gr_full;

    always_comb begin
        advance  = a_valid_reg && (!a_pos_reg.produce || !m_valid_reg || m_tready);
        load_out = advance && a_pos_reg.produce;
        in_ready = !a_valid_reg || advance;
        gc_full  = EW'($signed(rd_mid)) - EW'($signed(mid_w1_reg));
        gr_full  = EW'($signed(bottom_held_reg)) - EW'($signed(top_held_reg));
    end

    // the row one back moves to two back, the new sample becomes one back
    assign wr_en   = advance;
    assign wr_addr = a_col_reg;
    assign wr_top  = rd_mid;
    assign wr_mid  = a_sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
            mid_w0_reg      <= '0;
            mid_w1_reg      <= '0;
            top_held_reg    <= '0;
            bottom_held_reg <= '0;
        end else begin
            if (in_xfer) begin
                a_valid_reg <= 1'b1;
            end else if (advance) begin
                a_valid_reg <= 1'b0;
            end
            if (advance) begin
                mid_w1_reg      <= mid_w0_reg;
                mid_w0_reg      <= rd_mid;
                top_held_reg    <= rd_top;
                bottom_held_reg <= a_sample_reg;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            a_sample_reg <= in_sample;
            a_pos_reg    <= in_pos;
            a_col_reg    <= in_col;
        end
        if (load_out) begin
            row_out_reg  <= a_pos_reg.center_row;
            col_out_reg  <= a_pos_reg.center_col;
            gc_out_reg   <= gc_full[GRAD_W-1:0];
            gr_out_reg   <= gr_full[GRAD_W-1:0];
            last_out_reg <= a_pos_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {PAD_W'(0), gr_out_reg, gc_out_reg, col_out_reg, row_out_reg};
    assign m_tlast  = last_out_reg;

    a_hold_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && !in_ready |=> a_valid_reg)
        else $error("sample stage dropped a held item");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(a_valid_reg) && $past(a_pos_reg.produce))
        else $error("result without an interior sample");

endmodule
`default_nettype wire
